// ----- rtl/core/led_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pkg
// Shared types and constants of the local extremum detector: register
// indexes of the configuration port, field widths and the result record.
// ----------------------------------------------------------------------------
package led_pkg;

  // Fixed field widths
  localparam int PEAK_IDX_W = 12;
  localparam int HALF_WIN_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 1'b1;

  // Live configuration seen by the sequencer
  typedef struct packed {
    logic                  mode;         // 1 = maxima, 0 = minima
    logic [HALF_WIN_W-1:0] half_window;
  } led_cfg_t;

  // One result record
  typedef struct packed {
    logic [PEAK_IDX_W-1:0] peak_index;
    logic                  peak_valid;
    logic                  end_of_vector;
  } led_result_t;

endpackage

// ----- rtl/core/led_win_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_win_mem
// Sample window store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module led_win_mem #(
  parameter int DEPTH = 63,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic signed [WIDTH-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic signed [WIDTH-1:0] rd_data
);

  logic signed [WIDTH-1:0] mem_r [DEPTH];
  logic signed [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/led_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_out_buf
// Output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module led_out_buf
  import led_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  led_result_t push_data,
  output logic        out_valid,
  input  logic        out_ready,
  output led_result_t out_data
);

  logic        vld_r;
  logic        vld_nxt;
  led_result_t data_r;

  // Take a new record when empty or when the held one leaves this cycle
  assign push_ready = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (out_ready) begin
      vld_nxt = 1'b0;
    end
    if (push_valid && push_ready) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data_r <= push_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/core/led_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_seq
// Sequencer: stores samples in the window memory, scans the window of each
// candidate with one comparator and issues result records.
// ----------------------------------------------------------------------------
module led_seq
  import led_pkg::*;
#(
  parameter int MAX_LENGTH      = 4096,
  parameter int MAX_HALF_WINDOW = 31,
  parameter int SAMPLE_WIDTH    = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  led_cfg_t                                 cfg,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]           in_sample,
  input  logic                                     in_last,
  output logic                                     wr_en,
  output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]   wr_addr,
  output logic signed [SAMPLE_WIDTH-1:0]           wr_data,
  output logic                                     rd_en,
  output logic [$clog2(2*MAX_HALF_WINDOW+1)-1:0]   rd_addr,
  input  logic signed [SAMPLE_WIDTH-1:0]           rd_data,
  output logic                                     push_valid,
  input  logic                                     push_ready,
  output led_result_t                              push_data
);

  localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int WA        = $clog2(WIN_DEPTH);
  localparam int CW        = $clog2(MAX_LENGTH + 1);
  localparam int KW        = ((CW > WA) ? CW : WA) + 1;
  localparam int LW        = $clog2(WIN_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CENTER = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_FINAL  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  state_t                   ret_r, ret_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [WA-1:0]            wptr_r, wptr_nxt;
  logic [KW-1:0]            cand_r, cand_nxt;
  logic [KW-1:0]            lim_r, lim_nxt;
  logic [WA-1:0]            cptr_r, cptr_nxt;
  logic [WA-1:0]            rptr_r, rptr_nxt;
  logic [LW-1:0]            left_r, left_nxt;
  logic                     cen_pend_r, cen_pend_nxt;
  logic                     nb_v_r, nb_v_nxt;
  logic                     ok_r, ok_nxt;
  logic                     flush_r, flush_nxt;
  logic                     held_v_r, held_v_nxt;
  logic [PEAK_IDX_W-1:0]    held_idx_r, held_idx_nxt;
  logic signed [SAMPLE_WIDTH-1:0] center_r, center_nxt;
  led_result_t              res_r, res_nxt;

  logic [WA-1:0]            h_eff;
  logic [KW-1:0]            hk;
  logic [KW-1:0]            prior_cnt;
  logic [KW-1:0]            len;
  logic                     stored;
  logic                     accept;
  logic                     worse;
  logic [WA-1:0]            dist_lo;
  logic [KW-1:0]            hi_pos;
  logic [KW-1:0]            span;
  state_t                   after_cand;

  // Advance a window pointer with wrap
  function automatic logic [WA-1:0] ptr_inc(input logic [WA-1:0] p);
    logic [WA-1:0] r;
    r = (p == WA'(WIN_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  // Step a window pointer back by d (d below the depth)
  function automatic logic [WA-1:0] ptr_back(input logic [WA-1:0] p,
                                              input logic [WA-1:0] d);
    logic [WA:0] s;
    s = {1'b0, p} + (WA+1)'(WIN_DEPTH) - {1'b0, d};
    if (s >= (WA+1)'(WIN_DEPTH)) begin
      s = s - (WA+1)'(WIN_DEPTH);
    end
    return s[WA-1:0];
  endfunction

  // Clamp half window to the store size
  assign h_eff     = (int'(cfg.half_window) > MAX_HALF_WINDOW) ?
                     WA'(MAX_HALF_WINDOW) : WA'(cfg.half_window);
  assign hk        = KW'(h_eff);
  assign prior_cnt = KW'(cnt_r);
  assign stored    = (int'(cnt_r) < MAX_LENGTH);
  assign len       = stored ? prior_cnt + 1'b1 : prior_cnt;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Store the incoming sample at the write pointer
  assign wr_en   = accept && stored;
  assign wr_addr = wptr_r;
  assign wr_data = in_sample;

  // Window geometry of the current candidate
  assign dist_lo = (cand_r > hk) ? h_eff : WA'(cand_r);
  assign hi_pos  = ((cand_r + hk) > lim_r) ? lim_r : (cand_r + hk);
  assign span    = hi_pos - cand_r + KW'(dist_lo) + 1'b1;

  // Shared comparator
  assign worse = cfg.mode ? (rd_data > center_r) : (rd_data < center_r);

  // Where the flush goes after this candidate
  assign after_cand = ((cand_r + 1'b1) < lim_r) ? ST_CENTER : ST_FINAL;

  assign push_valid = (state_r == ST_EMIT);
  assign push_data  = res_r;

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    cnt_nxt      = cnt_r;
    wptr_nxt     = wptr_r;
    cand_nxt     = cand_r;
    lim_nxt      = lim_r;
    cptr_nxt     = cptr_r;
    rptr_nxt     = rptr_r;
    left_nxt     = left_r;
    cen_pend_nxt = cen_pend_r;
    nb_v_nxt     = nb_v_r;
    ok_nxt       = ok_r;
    flush_nxt    = flush_r;
    held_v_nxt   = held_v_r;
    held_idx_nxt = held_idx_r;
    center_nxt   = center_r;
    res_nxt      = res_r;
    rd_en        = 1'b0;
    rd_addr      = rptr_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (stored) begin
            cnt_nxt  = cnt_r + 1'b1;
            wptr_nxt = ptr_inc(wptr_r);
          end
          flush_nxt = in_last;
          if (!in_last) begin
            // Decide the position half a window back
            if (stored && (prior_cnt > hk)) begin
              cand_nxt  = prior_cnt - hk;
              lim_nxt   = prior_cnt;
              cptr_nxt  = ptr_back(wptr_r, h_eff);
              state_nxt = ST_CENTER;
            end
          end else begin
            // Flush every pending position of the vector
            cnt_nxt  = '0;
            wptr_nxt = '0;
            lim_nxt  = len - 1'b1;
            if (prior_cnt > hk) begin
              cand_nxt = prior_cnt - hk;
              cptr_nxt = ptr_back(wptr_r, h_eff);
            end else begin
              cand_nxt = KW'(1);
              cptr_nxt = WA'(1);
            end
            if (((prior_cnt > hk) ? (prior_cnt - hk + 1'b1) : KW'(2)) < len) begin
              state_nxt = ST_CENTER;
            end else begin
              state_nxt = ST_FINAL;
            end
          end
        end
      end

      ST_CENTER: begin
        // Fetch the candidate, set up the neighbor sweep
        rd_en        = 1'b1;
        rd_addr      = cptr_r;
        rptr_nxt     = ptr_back(cptr_r, dist_lo);
        left_nxt     = LW'(span);
        cen_pend_nxt = 1'b1;
        nb_v_nxt     = 1'b0;
        ok_nxt       = 1'b1;
        state_nxt    = ST_SCAN;
      end

      ST_SCAN: begin
        // Issue one read a cycle, compare what returns
        if (left_r != '0) begin
          rd_en    = 1'b1;
          rptr_nxt = ptr_inc(rptr_r);
          left_nxt = left_r - 1'b1;
        end
        nb_v_nxt = (left_r != '0);
        if (cen_pend_r) begin
          center_nxt   = rd_data;
          cen_pend_nxt = 1'b0;
        end
        if (nb_v_r && worse) begin
          ok_nxt = 1'b0;
        end
        if ((left_r == '0) && !nb_v_r && !cen_pend_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (!flush_r) begin
          if (ok_r) begin
            res_nxt   = '{peak_index: PEAK_IDX_W'(cand_r), peak_valid: 1'b1,
                          end_of_vector: 1'b0};
            ret_nxt   = ST_IDLE;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          // Keep one peak back so the last one can carry the end mark
          cand_nxt = cand_r + 1'b1;
          cptr_nxt = ptr_inc(cptr_r);
          if (ok_r) begin
            held_v_nxt   = 1'b1;
            held_idx_nxt = PEAK_IDX_W'(cand_r);
          end
          if (ok_r && held_v_r) begin
            res_nxt   = '{peak_index: held_idx_r, peak_valid: 1'b1,
                          end_of_vector: 1'b0};
            ret_nxt   = after_cand;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = after_cand;
          end
        end
      end

      ST_FINAL: begin
        if (held_v_r) begin
          res_nxt = '{peak_index: held_idx_r, peak_valid: 1'b1, end_of_vector: 1'b1};
        end else begin
          res_nxt = '{peak_index: '0, peak_valid: 1'b0, end_of_vector: 1'b1};
        end
        held_v_nxt = 1'b0;
        ret_nxt    = ST_IDLE;
        state_nxt  = ST_EMIT;
      end

      ST_EMIT: begin
        if (push_ready) begin
          state_nxt = ret_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ret_r      <= ST_IDLE;
      cnt_r      <= '0;
      wptr_r     <= '0;
      left_r     <= '0;
      cen_pend_r <= 1'b0;
      nb_v_r     <= 1'b0;
      flush_r    <= 1'b0;
      held_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      cnt_r      <= cnt_nxt;
      wptr_r     <= wptr_nxt;
      left_r     <= left_nxt;
      cen_pend_r <= cen_pend_nxt;
      nb_v_r     <= nb_v_nxt;
      flush_r    <= flush_nxt;
      held_v_r   <= held_v_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    lim_r      <= lim_nxt;
    cptr_r     <= cptr_nxt;
    rptr_r     <= rptr_nxt;
    ok_r       <= ok_nxt;
    held_idx_r <= held_idx_nxt;
    center_r   <= center_nxt;
    res_r      <= res_nxt;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_LENGTH)
    else $error("sample count beyond vector limit");

  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !held_v_r)
    else $error("held peak left over at idle");

  a_mid_no_eov: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !flush_r) |-> !res_r.end_of_vector)
    else $error("end mark on a mid-vector result");

  a_flush_end_eov: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && flush_r && ret_r == ST_IDLE) |-> res_r.end_of_vector)
    else $error("flush ended without end mark");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && left_r == '0 && !nb_v_r && !cen_pend_r)
      |=> (state_r == ST_DECIDE))
    else $error("sweep finished without decision");
`endif

endmodule

// ----- rtl/core/local_extremum_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_extremum_detector
// Reports indices of local minima or maxima of a streamed signed profile.
// ----------------------------------------------------------------------------
// Samples stream in one per transfer; in_last ends the vector. A position is
// a peak when it is neither first nor last and no sample within half_window
// on either side (clipped at the vector ends) is strictly lower (mode 0) or
// strictly higher (mode 1). Each decision trails the input by half_window
// samples; the last sample flushes the pending positions and the final
// result carries end_of_vector (a lone result with peak_valid 0 if no peak
// remains). Samples past MAX_LENGTH are dropped until last. The window lives
// in a single-port-read memory of 2*MAX_HALF_WINDOW+1 entries, and every
// decision sweeps it with one comparator: a sample that decides nothing
// leaves in_ready high, one that decides a position holds in_ready low while
// the clipped window (up to 2*half_window+1 samples) is read one sample at a
// time, and the last sample does so for each of up to half_window pending
// positions, and each result waits in the emit state until the output buffer
// takes it. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module local_extremum_detector
  import led_pkg::*;
#(
  parameter int MAX_LENGTH      = 4096,
  parameter int MAX_HALF_WINDOW = 31,
  parameter int SAMPLE_WIDTH    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [PEAK_IDX_W-1:0]         out_peak_index,
  output logic                          out_peak_valid,
  output logic                          out_end_of_vector
);

  localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int WA        = $clog2(WIN_DEPTH);

  logic                          mode_r;
  logic [HALF_WIN_W-1:0]         half_window_r;
  led_cfg_t                      cfg;
  logic                          wr_en;
  logic [WA-1:0]                 wr_addr;
  logic signed [SAMPLE_WIDTH-1:0] wr_data;
  logic                          rd_en;
  logic [WA-1:0]                 rd_addr;
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  logic                          push_valid;
  logic                          push_ready;
  led_result_t                   push_data;
  led_result_t                   out_data;

  // Configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 1'b0;
      half_window_r <= HALF_WIN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:        mode_r        <= cfg_data[0];
        CFG_HALF_WINDOW: half_window_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{mode: mode_r, half_window: half_window_r};

  led_seq #(
    .MAX_LENGTH      (MAX_LENGTH),
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_last    (in_last),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  led_win_mem #(
    .DEPTH (WIN_DEPTH),
    .WIDTH (SAMPLE_WIDTH)
  ) u_win_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  led_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Split the result record onto the ports
  assign out_peak_index    = out_data.peak_index;
  assign out_peak_valid    = out_data.peak_valid;
  assign out_end_of_vector = out_data.end_of_vector;

endmodule
